// ===== sv/frac_pkg.sv =====
// fraction reducer package: value width, counter width, magnitude type
// and the result type of the shared subtract unit; no dependencies
package frac_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] mag_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam mag_t TOP_MAG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam mag_t MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam cnt_t CNT_LAST = cnt_t'(VALUE_WIDTH - 1);

  typedef struct packed {
    mag_t diff;
    logic borrow;
  } alu_res_t;

endpackage

// ===== sv/frac_if.sv =====
// item channels of the fraction reducer, input and result side
// depends on frac_pkg
interface frac_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [frac_pkg::VALUE_WIDTH-1:0] numerator;
  logic signed [frac_pkg::VALUE_WIDTH-1:0] denominator;

  modport source(output valid, numerator, denominator, input ready);
  modport sink(input valid, numerator, denominator, output ready);
endinterface

interface frac_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [frac_pkg::VALUE_WIDTH-1:0] reduced_numerator;
  logic        [frac_pkg::VALUE_WIDTH-2:0] reduced_denominator;
  logic                                     zero_denominator_error;

  modport source(output valid, reduced_numerator, reduced_denominator,
                 zero_denominator_error, input ready);
  modport sink(input valid, reduced_numerator, reduced_denominator,
               zero_denominator_error, output ready);
endinterface

// ===== sv/frac_alu.sv =====
// shared unsigned subtract and compare unit of the fraction reducer
// depends on frac_pkg
module frac_alu (
  input  frac_pkg::mag_t     x_i,
  input  frac_pkg::mag_t     y_i,
  output frac_pkg::alu_res_t res_o
);

  logic [frac_pkg::VALUE_WIDTH:0] wide;

  assign wide         = {1'b0, x_i} - {1'b0, y_i};
  assign res_o.diff   = wide[frac_pkg::VALUE_WIDTH-1:0];
  assign res_o.borrow = wide[frac_pkg::VALUE_WIDTH];

endmodule

// ===== sv/fraction_reducer.sv =====
// fraction reducer top level: binary gcd and two restoring divisions on one
// shared subtract unit; depends on frac_pkg, frac_if and frac_alu
// a zero numerator or denominator goes straight to the finish step; otherwise the gcd
// strips the common twos, runs its shift, subtract and swap steps, restores the twos,
// and then the numerator and the denominator are each divided by it
// throughput: one item at a time, the next is taken once the sequencer is idle again
// reset: asynchronous active low, sequencer idle and result register empty
module fraction_reducer (
  input  logic            clk_i,
  input  logic            rst_ni,
  frac_in_if.sink         in_i,
  frac_out_if.source      out_o
);

  localparam int W = frac_pkg::VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_TWOS, S_ODDA, S_RUN, S_SHL, S_DIVN, S_DIVD, S_FIN
  } state_e;

  state_e             state_q;
  frac_pkg::mag_t     a_q, b_q, nmag_q, dmag_q, dq_q, rem_q, rn_q;
  frac_pkg::cnt_t     cnt_q;
  logic               neg_q, err_q;
  logic               out_valid_q;
  logic signed [W-1:0] onum_q;
  logic [W-2:0]       oden_q;
  logic               oerr_q;

  frac_pkg::mag_t     in_nmag, in_dmag, alu_x, rem2, rn_sat, rd_sat;
  frac_pkg::alu_res_t alu_res;
  logic               qbit;

  // magnitudes, the most negative value maps onto the top bit
  assign in_nmag = in_i.numerator[W-1]   ? frac_pkg::mag_t'(-in_i.numerator)
                                         : frac_pkg::mag_t'(in_i.numerator);
  assign in_dmag = in_i.denominator[W-1] ? frac_pkg::mag_t'(-in_i.denominator)
                                         : frac_pkg::mag_t'(in_i.denominator);

  assign rem2  = {rem_q[W-2:0], dq_q[W-1]};
  assign alu_x = (state_q == S_RUN) ? b_q : rem2;
  assign qbit  = ~alu_res.borrow;

  frac_alu u_alu (
    .x_i  (alu_x),
    .y_i  (a_q),
    .res_o(alu_res)
  );

  assign rn_sat = (rn_q == frac_pkg::TOP_MAG) ? frac_pkg::MAX_POS : rn_q;
  assign rd_sat = (dq_q == frac_pkg::TOP_MAG) ? frac_pkg::MAX_POS : dq_q;

  assign in_i.ready                   = (state_q == S_IDLE);
  assign out_o.valid                  = out_valid_q;
  assign out_o.reduced_numerator      = onum_q;
  assign out_o.reduced_denominator    = oden_q;
  assign out_o.zero_denominator_error = oerr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      nmag_q      <= '0;
      dmag_q      <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      rn_q        <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      onum_q      <= '0;
      oden_q      <= '0;
      oerr_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            a_q    <= in_nmag;
            b_q    <= in_dmag;
            nmag_q <= in_nmag;
            dmag_q <= in_dmag;
            cnt_q  <= '0;
            neg_q  <= in_i.numerator[W-1] ^ in_i.denominator[W-1];
            err_q  <= (in_dmag == '0);
            if (in_dmag == '0) begin
              rn_q    <= '0;
              dq_q    <= '0;
              state_q <= S_FIN;
            end else if (in_nmag == '0) begin
              rn_q    <= '0;
              dq_q    <= frac_pkg::mag_t'(1);
              state_q <= S_FIN;
            end else begin
              state_q <= S_TWOS;
            end
          end
        end
        // strip common factors of two
        S_TWOS: begin
          if (!a_q[0] && !b_q[0]) begin
            a_q   <= a_q >> 1;
            b_q   <= b_q >> 1;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            state_q <= S_ODDA;
          end
        end
        S_ODDA: begin
          if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else begin
            state_q <= S_RUN;
          end
        end
        // a stays odd, b goes down to zero
        S_RUN: begin
          if (b_q == '0) begin
            state_q <= S_SHL;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (alu_res.borrow) begin
            a_q <= b_q;
            b_q <= a_q;
          end else begin
            b_q <= alu_res.diff;
          end
        end
        // put the common twos back, a then holds the gcd
        S_SHL: begin
          if (cnt_q == '0) begin
            dq_q    <= nmag_q;
            rem_q   <= '0;
            state_q <= S_DIVN;
          end else begin
            a_q   <= a_q << 1;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIVN: begin
          if (cnt_q == frac_pkg::CNT_LAST) begin
            rn_q    <= {dq_q[W-2:0], qbit};
            dq_q    <= dmag_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIVD;
          end else begin
            dq_q  <= {dq_q[W-2:0], qbit};
            rem_q <= qbit ? alu_res.diff : rem2;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIVD: begin
          dq_q  <= {dq_q[W-2:0], qbit};
          rem_q <= qbit ? alu_res.diff : rem2;
          if (cnt_q == frac_pkg::CNT_LAST) begin
            cnt_q   <= '0;
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            onum_q      <= neg_q ? -$signed(rn_sat) : $signed(rn_sat);
            oden_q      <= rd_sat[W-2:0];
            oerr_q      <= err_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && oerr_q |-> onum_q == '0 && oden_q == '0)
    else $error("error item with nonzero fields");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !oerr_q |-> oden_q != '0)
    else $error("zero denominator without error flag");

  a_gcd_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> a_q[0])
    else $error("gcd operand lost its odd value");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVN || state_q == S_DIVD |-> rem_q < a_q)
    else $error("division remainder not below divisor");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench for fraction_reducer: directed and random fractions, each result
// checked against a lowest-terms predictor kept in a small scoreboard class
// depends on frac_pkg, frac_if and the fraction_reducer rtl
module tb;

  localparam int W = frac_pkg::VALUE_WIDTH;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 6 * frac_pkg::VALUE_WIDTH + 16;
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};

  typedef struct {
    logic signed [W-1:0] num;
    logic [W-2:0]        den;
    logic                err;
  } reduction_t;

  class lowest_terms_board;
    reduction_t pending_reductions[$];
    int         errors;

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    function reduction_t reduce_fraction(logic signed [W-1:0] n, logic signed [W-1:0] d);
      reduction_t res;
      frac_pkg::mag_t nm, dm, a, b, r, qn, qd;
      logic nneg, dneg;
      nneg = n[W-1];
      dneg = d[W-1];
      nm = nneg ? frac_pkg::mag_t'(~n + 1'b1) : frac_pkg::mag_t'(n);
      dm = dneg ? frac_pkg::mag_t'(~d + 1'b1) : frac_pkg::mag_t'(d);
      res.err = 1'b0;
      if (dm == '0) begin
        res.num = '0;
        res.den = '0;
        res.err = 1'b1;
        return res;
      end
      if (nm == '0) begin
        res.num = '0;
        res.den = (W-1)'(1);
        return res;
      end
      a = nm;
      b = dm;
      while (b != '0) begin
        r = a % b;
        a = b;
        b = r;
      end
      qn = nm / a;
      qd = dm / a;
      if (qn > frac_pkg::MAX_POS) qn = frac_pkg::MAX_POS;
      if (qd > frac_pkg::MAX_POS) qd = frac_pkg::MAX_POS;
      res.num = (nneg != dneg) ? -qn : qn;
      res.den = qd[W-2:0];
      return res;
    endfunction

    function void note_fraction(logic signed [W-1:0] n, logic signed [W-1:0] d);
      pending_reductions.push_back(reduce_fraction(n, d));
    endfunction

    task check_reduction(logic signed [W-1:0] num, logic [W-2:0] den, logic err);
      reduction_t want;
      if (pending_reductions.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d err %b", num, den, err));
        return;
      end
      want = pending_reductions.pop_front();
      if (num !== want.num)
        report($sformatf("numerator %0d, want %0d", num, want.num));
      if (den !== want.den)
        report($sformatf("denominator %0d, want %0d", den, want.den));
      if (err !== want.err)
        report($sformatf("zero denominator flag %b, want %b", err, want.err));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   cycle_count;
  lowest_terms_board board;

  frac_in_if  tx();
  frac_out_if rx();

  fraction_reducer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tx.sink),
    .out_o  (rx.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n) rx.ready <= ($urandom_range(99) >= stall_pct);
    else rx.ready <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && rx.valid === 1'b1 && rx.ready === 1'b1)
      board.check_reduction(rx.reduced_numerator, rx.reduced_denominator,
                            rx.zero_denominator_error);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_fraction(logic signed [W-1:0] n, logic signed [W-1:0] d);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      tx.valid = 1'b0;
      @(negedge clk);
    end
    tx.valid       = 1'b1;
    tx.numerator   = n;
    tx.denominator = d;
    do @(posedge clk); while (tx.ready !== 1'b1);
    board.note_fraction(n, d);
  endtask

  task automatic pick_fraction(output logic signed [W-1:0] n, output logic signed [W-1:0] d);
    int kind;
    int gb;
    logic [W-1:0] g, a, b;
    kind = $urandom_range(99);
    if (kind < 30) begin
      n = $urandom;
      d = $urandom;
    end else if (kind < 60) begin
      gb = $urandom_range(1, 20);
      g  = ($urandom >> (32 - gb)) + 1;
      a  = $urandom >> $urandom_range(gb + 1, 31);
      b  = $urandom >> $urandom_range(gb + 1, 31);
      n  = a * g;
      d  = b * g;
    end else if (kind < 75) begin
      n = $urandom_range(0, 40);
      d = $urandom_range(0, 40);
    end else if (kind < 85) begin
      n = (32'd1 << $urandom_range(0, 31)) * $urandom_range(1, 3);
      d = (32'd1 << $urandom_range(0, 31)) * $urandom_range(1, 3);
    end else if (kind < 92) begin
      n = $urandom;
      d = $urandom;
      if ($urandom_range(1)) n = '0;
      else d = '0;
    end else begin
      b = $urandom >> $urandom_range(4, 31);
      a = b * $urandom_range(1, 15);
      if ($urandom_range(1)) begin
        n = a;
        d = b;
      end else begin
        n = b;
        d = a;
      end
    end
    if ($urandom_range(1)) n = -n;
    if ($urandom_range(1)) d = -d;
  endtask

  initial begin
    logic signed [W-1:0] n, d;
    board       = new;
    rst_n       = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    tx.valid    = 1'b0;
    tx.numerator   = '0;
    tx.denominator = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero denominator, zero numerator, sign moves, most negative and largest values, common factors
    send_fraction(0, 0);
    send_fraction(MAX_V, 0);
    send_fraction(MIN_V, 0);
    send_fraction(-1, 0);
    send_fraction(0, 5);
    send_fraction(0, MIN_V);
    send_fraction(0, -7);
    send_fraction(6, -4);
    send_fraction(-6, -4);
    send_fraction(-6, 4);
    send_fraction(MIN_V, MIN_V);
    send_fraction(MIN_V, 1);
    send_fraction(MIN_V, -1);
    send_fraction(1, MIN_V);
    send_fraction(-1, MIN_V);
    send_fraction(MIN_V, 2);
    send_fraction(MAX_V, MAX_V);
    send_fraction(MAX_V, MIN_V);
    send_fraction(MIN_V, MAX_V);
    send_fraction(MAX_V, 1);
    send_fraction(1, MAX_V);
    send_fraction(-MAX_V, -1);
    send_fraction(32'sd12345 * 65536, 32'sd3 * 65536);
    send_fraction(1, 1);
    send_fraction(-1, 1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick_fraction(n, d);
        send_fraction(n, d);
      end
    end

    @(negedge clk);
    tx.valid = 1'b0;
    while (board.pending_reductions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_reductions.size() != 0)
      board.report($sformatf("%0d results never came", board.pending_reductions.size()));
    if (board.errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
